[hdl/rpa_pkg.sv]
// shared types and constants of the refcounted page allocator
package rpa_pkg;

  localparam int PAGE_W         = 15;
  localparam int END_W          = 16;
  localparam int REF_W          = 8;
  localparam int OP_W           = 3;
  localparam int ST_W           = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int PAGE_COUNT_DEF = 32768;
  localparam int COUNT_BITS_DEF = 8;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 15'd0;
  localparam logic [END_W-1:0]  END_PAGE_RST   = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PAGE = 1'd0,
    CFG_END_PAGE   = 1'd1
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_ADD   = 3'd2,
    OP_READ  = 3'd3,
    OP_INIT  = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_OOM   = 3'd1,
    ST_RANGE = 3'd2,
    ST_OVF   = 3'd3,
    ST_UNREF = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_POP_RD,
    S_CHK_LO,
    S_CHK_HI,
    S_CHK_TOP,
    S_MOD,
    S_PUSH,
    S_CLR,
    S_BOUND,
    S_FILL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PAGE_W-1:0] page;
  } in_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    logic [REF_W-1:0]  ref_count;
    logic              released;
    logic [ST_W-1:0]   status;
  } out_t;

endpackage

[hdl/rpa_ram.sv]
// generic single-write, single-read ram with registered read data
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rpa_alu.sv]
// shared add / subtract-compare unit of the allocator sequencer
module rpa_alu #(
  parameter int W = 17
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         lt_o
);

  logic [W:0] sum;

  always_comb begin
    if (sub_i) begin
      sum = {1'b0, a_i} + {1'b0, ~b_i} + {{W{1'b0}}, 1'b1};
    end else begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o = sum[W-1:0];
  // no carry out of a - b means a borrow, so a < b
  assign lt_o  = sub_i & ~sum[W];

endmodule

[hdl/refcounted_page_allocator.sv]
// top level: reference counted page allocator with a lifo free pool
//
//   channel | direction | handshake             | beat
//   in      | input     | in_valid_i/in_stall_o | in_t: operation, page
//   out     | output    | out_valid_o/out_stall_i | out_t: page, count, released, status
//   cfg     | input     | cfg_valid_i/cfg_ready_o | register index, write data
//
// one operation at a time over the shared add/compare unit and the two rams; the result loads once
// allocate, read, add reference or free is through all of its states, sooner for an empty pool, a
// page out of range or an unused code; the next beat goes in the cycle after the result loads
// initialize clears every count, then pools each page in [first page, min(end page, PAGE_COUNT))
// rst_ni clears pool depth and handshake state, resets the config registers; rams are not cleared
// a result held by out_stall_i still lets the next beat in; a second one waits in the last state
module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [END_W-1:0]     cfg_data_i
);

  localparam int AW = $clog2(PAGE_COUNT);
  localparam int DW = $clog2(PAGE_COUNT + 1);
  localparam int UW = (DW > 17) ? DW : 17;
  localparam int XW = (COUNT_BITS > REF_W) ? COUNT_BITS : REF_W;

  state_e state_q, state_d;

  logic [PAGE_W-1:0]     first_q;
  logic [END_W-1:0]      end_q;
  logic [DW-1:0]         depth_q, depth_d;
  logic                  out_valid_q;
  out_t                  out_data_q;

  logic [OP_W-1:0]       op_q, op_d;
  logic [PAGE_W-1:0]     page_q, page_d;
  logic [UW-1:0]         idx_q, idx_d;
  logic [UW-1:0]         bound_q, bound_d;
  logic [PAGE_W-1:0]     rpage_q, rpage_d;
  logic [COUNT_BITS-1:0] rcnt_q, rcnt_d;
  logic                  rrel_q, rrel_d;
  status_e               rst_q, rst_d;

  logic [UW-1:0]         unit_a, unit_b, unit_res;
  logic                  unit_sub, unit_lt;

  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  stk_we;
  logic [AW-1:0]         stk_waddr;
  logic [PAGE_W-1:0]     stk_wdata, stk_rdata;

  logic                  in_fire, out_free, out_load;
  logic [UW-1:0]         page_x, stk_rx;
  logic [XW-1:0]         cnt_x;
  out_t                  out_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign page_x      = UW'(page_q);
  assign stk_rx      = UW'(stk_rdata);

  rpa_alu #(.W(UW)) u_alu (
    .a_i   (unit_a),
    .b_i   (unit_b),
    .sub_i (unit_sub),
    .res_o (unit_res),
    .lt_o  (unit_lt)
  );

  rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAGE_COUNT)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (page_x[AW-1:0]),
    .rdata_o (cnt_rdata)
  );

  // free pool, read address follows the pop decrement
  rpa_ram #(.WIDTH(PAGE_W), .DEPTH(PAGE_COUNT)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (unit_res[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.operation)
            OP_ALLOC: state_d = S_POP;
            OP_FREE:  state_d = S_CHK_LO;
            OP_ADD:   state_d = S_CHK_LO;
            OP_READ:  state_d = S_CHK_LO;
            OP_INIT:  state_d = S_CLR;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_POP:     state_d = unit_lt ? S_DONE : S_POP_RD;
      S_POP_RD:  state_d = S_DONE;
      S_CHK_LO:  state_d = unit_lt ? S_DONE : S_CHK_HI;
      S_CHK_HI:  state_d = unit_lt ? S_CHK_TOP : S_DONE;
      S_CHK_TOP: state_d = unit_lt ? S_MOD : S_DONE;
      S_MOD: begin
        if ((op_q == OP_FREE) && !unit_lt && (unit_res[COUNT_BITS-1:0] == '0)) begin
          state_d = S_PUSH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PUSH:    state_d = S_DONE;
      S_CLR:     state_d = (idx_q == UW'(PAGE_COUNT - 1)) ? S_BOUND : S_CLR;
      S_BOUND:   state_d = S_FILL;
      S_FILL:    state_d = unit_lt ? S_FILL : S_DONE;
      S_DONE:    state_d = out_free ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    unit_a    = '0;
    unit_b    = '0;
    unit_sub  = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = page_x[AW-1:0];
    cnt_wdata = '0;
    stk_we    = 1'b0;
    stk_waddr = depth_q[AW-1:0];
    stk_wdata = page_q;
    op_d      = op_q;
    page_d    = page_q;
    idx_d     = idx_q;
    bound_d   = bound_q;
    depth_d   = depth_q;
    rpage_d   = rpage_q;
    rcnt_d    = rcnt_q;
    rrel_d    = rrel_q;
    rst_d     = rst_q;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_data_i.operation;
          page_d  = in_data_i.page;
          idx_d   = '0;
          rpage_d = in_data_i.page;
          rcnt_d  = '0;
          rrel_d  = 1'b0;
          rst_d   = ST_OK;
        end
      end
      S_POP: begin
        unit_a   = UW'(depth_q);
        unit_b   = UW'(1);
        unit_sub = 1'b1;
        if (unit_lt) begin
          rpage_d = '0;
          rst_d   = ST_OOM;
        end else begin
          depth_d = unit_res[DW-1:0];
        end
      end
      S_POP_RD: begin
        cnt_we    = 1'b1;
        cnt_waddr = stk_rx[AW-1:0];
        cnt_wdata = COUNT_BITS'(1);
        rpage_d   = stk_rdata;
        rcnt_d    = COUNT_BITS'(1);
      end
      S_CHK_LO: begin
        unit_a   = page_x;
        unit_b   = UW'(first_q);
        unit_sub = 1'b1;
        if (unit_lt) begin
          rst_d = ST_RANGE;
        end
      end
      S_CHK_HI: begin
        unit_a   = page_x;
        unit_b   = UW'(end_q);
        unit_sub = 1'b1;
        if (!unit_lt) begin
          rst_d = ST_RANGE;
        end
      end
      S_CHK_TOP: begin
        unit_a   = page_x;
        unit_b   = UW'(PAGE_COUNT);
        unit_sub = 1'b1;
        if (!unit_lt) begin
          rst_d = ST_RANGE;
        end
      end
      S_MOD: begin
        unit_a = UW'(cnt_rdata);
        unit_b = UW'(1);
        case (op_q)
          OP_ADD: begin
            // carry into the bit above the count means it was saturated
            if (unit_res[COUNT_BITS]) begin
              rst_d  = ST_OVF;
              rcnt_d = cnt_rdata;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = unit_res[COUNT_BITS-1:0];
              rcnt_d    = unit_res[COUNT_BITS-1:0];
            end
          end
          OP_FREE: begin
            unit_sub = 1'b1;
            if (unit_lt) begin
              rst_d = ST_UNREF;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = unit_res[COUNT_BITS-1:0];
              rcnt_d    = unit_res[COUNT_BITS-1:0];
            end
          end
          default: begin
            rcnt_d = cnt_rdata;
          end
        endcase
      end
      S_PUSH: begin
        unit_a   = UW'(depth_q);
        unit_b   = UW'(PAGE_COUNT);
        unit_sub = 1'b1;
        // a full pool drops the page
        if (unit_lt) begin
          stk_we  = 1'b1;
          depth_d = depth_q + DW'(1);
          rrel_d  = 1'b1;
        end
      end
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_q[AW-1:0];
        cnt_wdata = '0;
        idx_d     = idx_q + UW'(1);
      end
      S_BOUND: begin
        unit_a   = UW'(end_q);
        unit_b   = UW'(PAGE_COUNT);
        unit_sub = 1'b1;
        bound_d  = unit_lt ? UW'(end_q) : UW'(PAGE_COUNT);
        idx_d    = UW'(first_q);
        depth_d  = '0;
      end
      S_FILL: begin
        unit_a   = idx_q;
        unit_b   = bound_q;
        unit_sub = 1'b1;
        if (unit_lt) begin
          stk_we    = 1'b1;
          stk_wdata = idx_q[PAGE_W-1:0];
          depth_d   = depth_q + DW'(1);
          idx_d     = idx_q + UW'(1);
        end else begin
          rpage_d = '0;
        end
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign cnt_x = XW'(rcnt_q);

  always_comb begin
    out_d.result_page = rpage_q;
    out_d.ref_count   = cnt_x[REF_W-1:0];
    out_d.released    = rrel_q;
    out_d.status      = rst_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      first_q     <= FIRST_PAGE_RST;
      end_q       <= END_PAGE_RST;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FIRST_PAGE: first_q <= cfg_data_i[PAGE_W-1:0];
          CFG_END_PAGE:   end_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    page_q  <= page_d;
    idx_q   <= idx_d;
    bound_q <= bound_d;
    rpage_q <= rpage_d;
    rcnt_q  <= rcnt_d;
    rrel_q  <= rrel_d;
    rst_q   <= rst_d;
    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
